[design/gbl_pkg.sv]
//------------------------------------------------------------------------------
// gbl_pkg
// Shared types and constants for the gap buffer list: word formats, op and
// status codes, controller states and the command that drives the cell row.
//------------------------------------------------------------------------------
`default_nettype none

package gbl_pkg;

   localparam int DEPTH      = 256;
   localparam int ELEM_WIDTH = 32;
   localparam int OP_W       = 2;
   localparam int POS_W      = 9;
   localparam int CNT_W      = 9;
   localparam int STAT_W     = 2;

   // op codes
   localparam logic [OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [POS_W-1:0]      position;
      logic [ELEM_WIDTH-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] read_value;
      logic [STAT_W-1:0]     status;
      logic [CNT_W-1:0]      count;
   } rsp_word_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SEEK,
      STATE_DONE
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_READ,
      ACT_WRITE,
      ACT_INSERT,
      ACT_DELETE
   } act_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_SHIFT,
      CELL_LOAD_HEAD,
      CELL_LOAD_TAIL
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [ELEM_WIDTH-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic         load;
      rsp_word_type word;
   } rsp_load_type;

endpackage

`default_nettype wire

[design/gap_buffer_list.sv]
// sequence: an accepted request goes from idle to seek, where the ring rotates
//   until the element sits at the port, then to done, which loads the
//   response word once the response slot is free; a rejected request skips seek
// handshake: a new request is taken only back in idle, after the last one is
//   answered; the single rotating cell ring is the limit
// reset: synchronous, clears element count, gap and handshake state; the
//   element cells are not cleared and need no clearing pass
//------------------------------------------------------------------------------
// gap_buffer_list
// Indexed list of fixed capacity kept as a gap buffer in a ring of cells.
//------------------------------------------------------------------------------
`default_nettype none

module gap_buffer_list (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gbl_pkg::req_word_type req_data,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output gbl_pkg::rsp_word_type      rsp_data
);

   // ring layout: cell 0 holds the element just after the gap, cells run
   // through the end of the list, wrap to element 0 and end just before the
   // gap; one rotate moves the gap one element to the right

   gbl_pkg::cell_cmd_type          cmd;
   gbl_pkg::rsp_load_type          rsp_load;
   logic [gbl_pkg::CNT_W-1:0]      count;
   logic [gbl_pkg::ELEM_WIDTH-1:0] head;
   logic                           rsp_free;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   gbl_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   // slot frees in the same cycle the waiting word is taken
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   gbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_data),
      .rsp_free  (rsp_free),
      .head      (head),
      .cmd       (cmd),
      .count     (count),
      .rsp_load  (rsp_load)
   );

   gbl_row u_row (
      .clock (clock),
      .cmd   (cmd),
      .count (count),
      .head  (head)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_load.word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[design/gbl_cell.sv]
//------------------------------------------------------------------------------
// gbl_cell
// One storage cell of the ring: holds one element and takes its neighbor's
// element on rotate or shift, or the new element on a load.
//------------------------------------------------------------------------------
`default_nettype none

module gbl_cell (
   input  wire logic                          clock,
   input  wire gbl_pkg::cell_cmd_type         cmd,
   input  wire logic                          is_last,
   input  wire logic                          is_tail,
   input  wire logic                          is_head,
   input  wire logic [gbl_pkg::ELEM_WIDTH-1:0] head_data,
   input  wire logic [gbl_pkg::ELEM_WIDTH-1:0] right_data,
   output logic      [gbl_pkg::ELEM_WIDTH-1:0] data
);

   logic [gbl_pkg::ELEM_WIDTH-1:0] data_ff;
   logic [gbl_pkg::ELEM_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         gbl_pkg::CELL_HOLD:      data_in = data_ff;
         gbl_pkg::CELL_ROTATE:    data_in = is_last ? head_data : right_data;
         gbl_pkg::CELL_SHIFT:     data_in = right_data;
         gbl_pkg::CELL_LOAD_HEAD: data_in = is_head ? cmd.value : data_ff;
         gbl_pkg::CELL_LOAD_TAIL: data_in = is_tail ? cmd.value : data_ff;
         default:                 data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[design/gbl_row.sv]
//------------------------------------------------------------------------------
// gbl_row
// Row of element cells closed into a ring. Cell 0 is the access port; the
// live elements fill cells 0 to count-1.
//------------------------------------------------------------------------------
`default_nettype none

module gbl_row (
   input  wire logic                          clock,
   input  wire gbl_pkg::cell_cmd_type         cmd,
   input  wire logic [gbl_pkg::CNT_W-1:0]      count,
   output logic      [gbl_pkg::ELEM_WIDTH-1:0] head
);

   logic [gbl_pkg::ELEM_WIDTH-1:0] cell_data [gbl_pkg::DEPTH];

   genvar i;
   generate
      for (i = 0; i < gbl_pkg::DEPTH; i++) begin : g_cell
         logic [gbl_pkg::ELEM_WIDTH-1:0] right;
         logic                           last_hit;
         logic                           tail_hit;

         // last cell wraps back to the port
         if (i < gbl_pkg::DEPTH - 1) begin : g_mid
            assign right = cell_data[i+1];
         end else begin : g_end
            assign right = cell_data[0];
         end

         assign last_hit = (count == gbl_pkg::CNT_W'(i + 1));
         assign tail_hit = (count == gbl_pkg::CNT_W'(i));

         gbl_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .is_last    (last_hit),
            .is_tail    (tail_hit),
            .is_head    (i == 0),
            .head_data  (cell_data[0]),
            .right_data (right),
            .data       (cell_data[i])
         );
      end
   endgenerate

   assign head = cell_data[0];

endmodule

`default_nettype wire

[design/gbl_ctrl.sv]
//------------------------------------------------------------------------------
// gbl_ctrl
// Request sequencer: checks range and fill, rotates the ring until the
// requested element sits at the port, then performs the operation.
//------------------------------------------------------------------------------
`default_nettype none

module gbl_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire gbl_pkg::req_word_type         req_word,
   input  wire logic                          rsp_free,
   input  wire logic [gbl_pkg::ELEM_WIDTH-1:0] head,
   output gbl_pkg::cell_cmd_type              cmd,
   output logic      [gbl_pkg::CNT_W-1:0]      count,
   output gbl_pkg::rsp_load_type              rsp_load
);

   localparam logic [gbl_pkg::CNT_W-1:0] FULL_CNT = gbl_pkg::CNT_W'(gbl_pkg::DEPTH);
   localparam logic [gbl_pkg::CNT_W-1:0] ONE      = gbl_pkg::CNT_W'(1);

   gbl_pkg::state_type              state_ff, state_in;
   gbl_pkg::act_type                act_ff, act_in;
   logic [gbl_pkg::STAT_W-1:0]      status_ff, status_in;
   logic [gbl_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [gbl_pkg::ELEM_WIDTH-1:0]  value_ff, value_in;
   logic [gbl_pkg::CNT_W-1:0]       target_ff, target_in;
   logic [gbl_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [gbl_pkg::CNT_W-1:0]       gap_ff, gap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbl_pkg::STATE_IDLE;
         count_ff <= '0;
         gap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gap_ff   <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      target_ff <= target_in;
   end

   always_comb begin
      logic [gbl_pkg::CNT_W-1:0] pos_c;
      pos_c     = req_word.position;
      state_in  = state_ff;
      act_in    = act_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      target_in = target_ff;
      count_in  = count_ff;
      gap_in    = gap_ff;
      req_ready = 1'b0;
      cmd.op    = gbl_pkg::CELL_HOLD;
      cmd.value = value_ff;
      rsp_load.load            = 1'b0;
      rsp_load.word.read_value = '0;
      rsp_load.word.status     = status_ff;
      rsp_load.word.count      = count_ff;

      case (state_ff)
         gbl_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pos_in    = req_word.position;
               value_in  = req_word.value;
               status_in = gbl_pkg::STAT_OK;
               act_in    = gbl_pkg::ACT_NONE;
               case (req_word.op)
                  gbl_pkg::OP_READ: begin
                     if (pos_c >= count_ff) status_in = gbl_pkg::STAT_RANGE;
                     else                   act_in    = gbl_pkg::ACT_READ;
                  end
                  gbl_pkg::OP_WRITE: begin
                     if (pos_c > count_ff)          status_in = gbl_pkg::STAT_RANGE;
                     else if (pos_c < count_ff)     act_in    = gbl_pkg::ACT_WRITE;
                     else if (count_ff >= FULL_CNT) status_in = gbl_pkg::STAT_FULL;
                     else                           act_in    = gbl_pkg::ACT_INSERT;
                  end
                  gbl_pkg::OP_INSERT: begin
                     if (pos_c > count_ff)          status_in = gbl_pkg::STAT_RANGE;
                     else if (count_ff >= FULL_CNT) status_in = gbl_pkg::STAT_FULL;
                     else                           act_in    = gbl_pkg::ACT_INSERT;
                  end
                  gbl_pkg::OP_DELETE: begin
                     if (pos_c >= count_ff) status_in = gbl_pkg::STAT_RANGE;
                     else                   act_in    = gbl_pkg::ACT_DELETE;
                  end
                  default: status_in = gbl_pkg::STAT_RANGE;
               endcase
               // append lands behind the last element, so seek element 0
               target_in = (pos_c == count_ff) ? '0 : pos_c;
               state_in  = (act_in == gbl_pkg::ACT_NONE) ? gbl_pkg::STATE_DONE
                                                         : gbl_pkg::STATE_SEEK;
            end
         end

         gbl_pkg::STATE_SEEK: begin
            if (gap_ff == target_ff) begin
               state_in = gbl_pkg::STATE_DONE;
            end else begin
               cmd.op = gbl_pkg::CELL_ROTATE;
               gap_in = (gap_ff == count_ff - ONE) ? '0 : gap_ff + ONE;
            end
         end

         gbl_pkg::STATE_DONE: begin
            if (rsp_free) begin
               rsp_load.load = 1'b1;
               state_in      = gbl_pkg::STATE_IDLE;
               case (act_ff)
                  gbl_pkg::ACT_NONE: begin
                     count_in = count_ff;
                  end
                  gbl_pkg::ACT_READ: begin
                     rsp_load.word.read_value = head;
                  end
                  gbl_pkg::ACT_WRITE: begin
                     cmd.op = gbl_pkg::CELL_LOAD_HEAD;
                  end
                  gbl_pkg::ACT_INSERT: begin
                     cmd.op   = gbl_pkg::CELL_LOAD_TAIL;
                     count_in = count_ff + ONE;
                     gap_in   = (pos_ff == count_ff) ? '0 : pos_ff + ONE;
                  end
                  gbl_pkg::ACT_DELETE: begin
                     rsp_load.word.read_value = head;
                     cmd.op   = gbl_pkg::CELL_SHIFT;
                     count_in = count_ff - ONE;
                     gap_in   = (pos_ff == count_ff - ONE) ? '0 : pos_ff;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_load.word.count = count_in;
            end
         end

         default: begin
            state_in = gbl_pkg::STATE_IDLE;
         end
      endcase
   end

   assign count = count_ff;

endmodule

`default_nettype wire
